// File: hw/rtl/i2c_master_bit_engine_defines.svh
// Assertion macros shared by the I2C master bit engine RTL.
// No dependencies; included by the top module, which carries the concurrent assertions.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CMBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cmbe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cmbe assertion failed");

`endif

// File: hw/rtl/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by the core and the top module of the engine.
`default_nettype none

package i2cmbe_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned BYTE_BITS = 8;

    // Command codes carried in the mode field; codes five to seven mean no command.
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    // One input item, last field in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic       sda_in;
        logic       send_nack;
        logic [7:0] tx_byte;
        logic [2:0] mode;
    } t_in_item;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic       ack_level;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/i2cmbe_pipe_reg.sv
// Valid/ready pipeline register holding one item of generic width.
// No dependencies; used for the input and the result stage of the engine.
`default_nettype none

module i2cmbe_pipe_reg #(
    parameter int unsigned WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // The stage takes a new item whenever it is empty or its item leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2cmbe_core.sv
// Bus sequencer of the I2C master bit engine: segment timer, phase machine and shifter.
// Depends on i2cmbe_pkg; steps once for every item passed from input to result stage.
`default_nettype none

module i2cmbe_core #(
    parameter int unsigned DIVIDER_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [i2cmbe_pkg::CFG_WIDTH-1:0]   i_cfg_wdata,
    input  wire logic                               i_step,
    input  wire i2cmbe_pkg::t_in_item               i_item,
    output i2cmbe_pkg::t_result                     o_result
);

    import i2cmbe_pkg::*;

    localparam int unsigned MaxWidth =
        (DIVIDER_WIDTH > CFG_WIDTH) ? DIVIDER_WIDTH : CFG_WIDTH;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_STOP_A,
        PH_STOP_B,
        PH_BYTE_LO,
        PH_BYTE_HI
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic                     r_is_read, n_is_read;
    logic [3:0]               r_bit_count, n_bit_count;
    logic [7:0]               r_shifter, n_shifter;
    logic [DIVIDER_WIDTH-1:0] r_divider, n_divider;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_nack, n_nack;
    logic                     r_ack_seen, n_ack_seen;
    logic [7:0]               r_rx_hold, n_rx_hold;
    logic [DIVIDER_WIDTH-1:0] r_seg_len, n_seg_len;

    logic                     done;
    logic                     load;
    logic                     drive;
    logic [DIVIDER_WIDTH-1:0] div_inc;
    logic [MaxWidth-1:0]      cfg_ext;
    logic [MaxWidth-1:0]      cfg_lim;
    logic [MaxWidth-1:0]      cfg_clamped;

    // The segment length is clamped once, when the register is written.
    always_comb begin
        cfg_ext     = MaxWidth'(i_cfg_wdata);
        cfg_lim     = MaxWidth'({DIVIDER_WIDTH{1'b1}});
        cfg_clamped = (cfg_ext == '0) ? MaxWidth'(1) : cfg_ext;
        if (cfg_clamped > cfg_lim) begin
            cfg_clamped = cfg_lim;
        end
        n_seg_len = cfg_clamped[DIVIDER_WIDTH-1:0];
    end

    always_comb begin
        n_phase     = r_phase;
        n_is_read   = r_is_read;
        n_bit_count = r_bit_count;
        n_shifter   = r_shifter;
        n_divider   = r_divider;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_nack      = r_nack;
        n_ack_seen  = r_ack_seen;
        n_rx_hold   = r_rx_hold;
        done        = 1'b0;
        load        = 1'b0;
        div_inc     = r_divider + DIVIDER_WIDTH'(1);

        if (r_phase != PH_IDLE) begin
            n_divider = div_inc;
            if (div_inc >= r_seg_len) begin
                n_divider = '0;
                unique case (r_phase)
                    PH_START_A: begin
                        n_phase = PH_START_B;
                        load    = 1'b1;
                    end
                    PH_START_B: begin
                        n_phase = PH_START_C;
                        load    = 1'b1;
                    end
                    PH_START_C: begin
                        n_phase = PH_IDLE;
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        done    = 1'b1;
                    end
                    PH_STOP_A: begin
                        n_phase = PH_STOP_B;
                        load    = 1'b1;
                    end
                    PH_STOP_B: begin
                        n_phase = PH_IDLE;
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        done    = 1'b1;
                    end
                    PH_BYTE_LO: begin
                        n_phase = PH_BYTE_HI;
                        load    = 1'b1;
                    end
                    PH_BYTE_HI: begin
                        if (r_bit_count < 4'(BYTE_BITS)) begin
                            // SDA is sampled as the high half of a data clock ends.
                            n_shifter   = {r_shifter[6:0], r_is_read & i_item.sda_in};
                            n_bit_count = r_bit_count + 4'd1;
                            n_phase     = PH_BYTE_LO;
                            load        = 1'b1;
                        end else begin
                            if (r_is_read) begin
                                n_rx_hold = r_shifter;
                            end else begin
                                n_ack_seen = i_item.sda_in;
                            end
                            n_phase = PH_IDLE;
                            n_scl   = 1'b0;
                            n_sda   = 1'b0;
                            done    = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else if (i_item.mode == MODE_START || i_item.mode == MODE_STOP ||
                     i_item.mode == MODE_WRITE || i_item.mode == MODE_READ) begin
            n_is_read   = (i_item.mode == MODE_READ);
            n_divider   = '0;
            n_bit_count = '0;
            load        = 1'b1;
            if (i_item.mode == MODE_START) begin
                n_phase = PH_START_A;
            end else if (i_item.mode == MODE_STOP) begin
                n_phase = PH_STOP_A;
            end else begin
                n_shifter = (i_item.mode == MODE_WRITE) ? i_item.tx_byte : 8'h00;
                n_nack    = i_item.send_nack;
                n_phase   = PH_BYTE_LO;
            end
        end

        // Data bits pull low for a zero on a write; the ack clock that ends the byte carries the
        // master's ack on a read and is released on a write.
        if (n_bit_count < 4'(BYTE_BITS)) begin
            drive = !n_is_read && !n_shifter[7];
        end else begin
            drive = n_is_read && !n_nack;
        end

        if (load) begin
            unique case (n_phase)
                PH_START_A: begin
                    n_sda = 1'b0;
                end
                PH_START_B: begin
                    n_scl = 1'b1;
                    n_sda = 1'b0;
                end
                PH_START_C: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                PH_STOP_A: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_STOP_B: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                PH_BYTE_LO: begin
                    n_scl = 1'b0;
                    n_sda = drive;
                end
                PH_BYTE_HI: begin
                    n_scl = 1'b1;
                    n_sda = drive;
                end
                default: begin
                    n_scl = r_scl;
                end
            endcase
        end

        o_result              = '0;
        o_result.scl_level    = n_scl;
        o_result.sda_pull_low = n_sda;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.rx_byte      = n_rx_hold;
        o_result.ack_level    = n_ack_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_is_read   <= 1'b0;
            r_bit_count <= '0;
            r_shifter   <= '0;
            r_divider   <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b0;
            r_nack      <= 1'b0;
            r_ack_seen  <= 1'b1;
            r_rx_hold   <= '0;
            r_seg_len   <= DIVIDER_WIDTH'(2);
        end else begin
            if (i_cfg_we) begin
                r_seg_len <= n_seg_len;
            end
            if (i_step) begin
                r_phase     <= n_phase;
                r_is_read   <= n_is_read;
                r_bit_count <= n_bit_count;
                r_shifter   <= n_shifter;
                r_divider   <= n_divider;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_nack      <= n_nack;
                r_ack_seen  <= n_ack_seen;
                r_rx_hold   <= n_rx_hold;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one item is one tick of the bus timebase.
// An accepted input item is held in the input register and passes, as the sequencer
// steps, into the result register, from which the result item is taken.
// Throughput: one item per cycle while the result side keeps up, with the sequencer
// stepping once between the input register and the result register.
// Reset (synchronous, active low) empties both stages, idles the sequencer with
// SCL released high and SDA released, and sets the half period to two ticks.
`default_nettype none
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine #(
    parameter int unsigned DIVIDER_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration: half period in ticks.
    input  wire logic                             i_cfg_we,
    input  wire logic [i2cmbe_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    // Input stream.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata from bit 0: mode[2:0], tx_byte[10:3], send_nack[11], sda_in[12], zeros.
    input  wire logic [15:0]                      s_axis_tdata,
    // Result stream.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata from bit 0: scl_level[0], sda_pull_low[1], busy_res[2], done_res[3],
    // rx_byte[11:4], ack_level[12], zeros.
    output logic [15:0]                           m_axis_tdata
);

    import i2cmbe_pkg::*;

    t_in_item in_item;
    t_result  result;
    logic     in_valid;
    logic     step;
    logic     res_ready;
    logic     res_valid;

    // The input register holds the item for the current tick. It moves into the
    // result register, and the sequencer steps, in the same cycle; the result
    // register in turn frees itself whenever the consumer takes its item, so a
    // new item is accepted every cycle while the result side keeps up.
    i2cmbe_pipe_reg #(
        .WIDTH ($bits(t_in_item))
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (in_valid),
        .i_ready (res_ready),
        .o_data  (in_item)
    );

    assign step = in_valid && res_ready;

    // The sequencer state only advances when an item actually passes, so a stall
    // on the result side freezes the bus timing along with the stream.
    i2cmbe_core #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (in_item),
        .o_result    (result)
    );

    i2cmbe_pipe_reg #(
        .WIDTH ($bits(t_result))
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (res_ready),
        .i_data  (result),
        .o_valid (res_valid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    assign m_axis_tvalid = res_valid;

    // A finished command never reports itself as still busy.
    `I2CMBE_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[2])

    // Input back-pressure only arises from a full input stage behind a stalled result.
    `I2CMBE_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, in_valid && m_axis_tvalid && !m_axis_tready)

    // Every item that steps the sequencer shows up as a result in the next cycle.
    `I2CMBE_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step, m_axis_tvalid)

endmodule

`default_nettype wire
